// ===== src/double_ended_queue_top_macros.svh =====
// assertion macros used by the checker file
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// checked outside reset
`define DQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dq_pkg.sv =====
package dq_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int DATA_W       = 32;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;

   localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // the action that every cell is given
   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_TO_BACK,
      ACT_TO_FRONT,
      ACT_LOAD_TAIL
   } action_type;

   typedef struct packed {
      action_type        action;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// ===== src/double_ended_queue_top.sv =====
// Bounded deque of signed 32-bit values, built as a row of CAPACITY cells
// with cell 0 at the front.
// Request channel (req_valid/req_ready): req_op selects push back, push
// front, pop front or clear; req_value is the value to push.
// Response channel (rsp_valid/rsp_ready): one response per request with the
// popped value, a status (ok, full, empty) and the occupancy afterwards.
// Push front and pop move every cell one place at once; push back loads the
// first free cell.
// The response is registered: it is valid in the cycle after the request transfer.
// Throughput: one request per cycle, set by the response register, as long
// as rsp_ready stays high.
// When the receiver stalls, the response is held and req_ready falls until
// the response transfers; it rises again in that same cycle.
// Reset clears the occupancy count and the response valid flag; cell
// contents are left as they are and are never read before being written.
module double_ended_queue_top #(
   parameter int CAPACITY = dq_pkg::CAPACITY_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dq_pkg::OP_W-1:0]     req_op,
   input  logic signed [dq_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [dq_pkg::DATA_W-1:0] rsp_value_out,
   output logic [dq_pkg::STATUS_W-1:0] rsp_status,
   output logic [CNT_W-1:0]            rsp_occupancy
);
   import dq_pkg::*;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [DATA_W-1:0] rsp_value_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;
   logic [CNT_W-1:0]  rsp_occupancy_ff;

   cell_cmd_type      cmd;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic              transfer;
   logic              full;
   logic              empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign transfer  = req_valid && req_ready;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);

   always_comb begin
      cmd.action    = ACT_HOLD;
      cmd.value     = req_value;
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      if (transfer) begin
         case (op_type'(req_op))
            OP_PUSH_BACK: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cmd.action = ACT_LOAD_TAIL;
                  count_in   = count_ff + 1'b1;
               end
            end
            OP_PUSH_FRONT: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cmd.action = ACT_TO_BACK;
                  count_in   = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_value_in  = POP_EMPTY_VALUE;
               end else begin
                  rsp_value_in = cell_data[0];
                  cmd.action   = ACT_TO_FRONT;
                  count_in     = count_ff - 1'b1;
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (transfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         rsp_value_ff     <= rsp_value_in;
         rsp_status_ff    <= rsp_status_in;
         rsp_occupancy_ff <= count_in;
      end
   end

   // cell 0 takes the pushed value on push front, the last cell keeps its own on pop
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] from_front;
      logic [DATA_W-1:0] from_back;
      if (i == 0) begin : g_head
         assign from_front = req_value;
      end else begin : g_body
         assign from_front = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign from_back = cell_data[i];
      end else begin : g_inner
         assign from_back = cell_data[i+1];
      end
      dq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .from_front (from_front),
         .from_back  (from_back),
         .data       (cell_data[i])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule

// ===== src/dq_cell.sv =====
module dq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                      clock,
   input  dq_pkg::cell_cmd_type      cmd,
   input  logic [CNT_W-1:0]          count,
   input  logic [dq_pkg::DATA_W-1:0] from_front,
   input  logic [dq_pkg::DATA_W-1:0] from_back,
   output logic [dq_pkg::DATA_W-1:0] data
);
   import dq_pkg::*;

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.action)
         ACT_TO_BACK:   data_in = from_front;
         ACT_TO_FRONT:  data_in = from_back;
         ACT_LOAD_TAIL: begin
            // only the first free cell takes the value
            if (count == MY_INDEX) begin
               data_in = cmd.value;
            end
         end
         default:       data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== src/dq_checker.sv =====
`include "double_ended_queue_top_macros.svh"

module dq_checker #(
   parameter int CAPACITY = dq_pkg::CAPACITY_DEF,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [dq_pkg::DATA_W-1:0]   rsp_value_out,
   input logic [dq_pkg::STATUS_W-1:0] rsp_status,
   input logic [CNT_W-1:0]            rsp_occupancy
);
   import dq_pkg::*;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   // a stalled response must hold
   `DQ_ASSERT(a_rsp_hold, clock, reset,
              rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out)
                 && $stable(rsp_status) && $stable(rsp_occupancy),
              "response changed while stalled")

   // refused push only when the row is full, and it reports zero
   `DQ_ASSERT(a_full_count, clock, reset,
              rsp_valid && rsp_status == ST_FULL
                 |-> rsp_occupancy == FULL_COUNT && rsp_value_out == '0,
              "full status with room left")

   // refused pop only when empty, and it reports all ones
   `DQ_ASSERT(a_empty_pop, clock, reset,
              rsp_valid && rsp_status == ST_EMPTY
                 |-> rsp_occupancy == '0 && rsp_value_out == POP_EMPTY_VALUE,
              "bad empty pop response")

   `DQ_ASSERT(a_occ_range, clock, reset, rsp_valid |-> rsp_occupancy <= FULL_COUNT,
              "occupancy above capacity")

   // nothing pending right after reset
   `DQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready,
                     "response valid after reset")

endmodule

bind double_ended_queue_top dq_checker #(
   .CAPACITY (CAPACITY),
   .CNT_W    (CNT_W)
) u_dq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value_out (rsp_value_out),
   .rsp_status    (rsp_status),
   .rsp_occupancy (rsp_occupancy)
);
